>>> rtl/tfn_pkg.sv
`timescale 1ns / 1ps
// Shared widths and the carried payload type of the triangle face normal unit.
// Depends on nothing; all other files import it.
package tfn_pkg;

  localparam int CW       = 16;             // vertex coordinate width, Q3.12
  localparam int EW       = CW + 1;         // edge vector width
  localparam int PW       = 2 * EW;         // edge product width
  localparam int XW       = PW + 1;         // cross product width
  localparam int TOPW     = $clog2(XW);     // leading bit position width
  localparam int NFB      = 14;             // normal fraction bits
  localparam int OW       = NFB + 2;        // normal component width
  localparam int NORM_TOP = 30;             // normalized magnitudes top out at this bit
  localparam int MW       = NORM_TOP + 1;   // normalized magnitude width
  localparam int SQW      = 2 * MW;         // square width
  localparam int SUMW     = SQW + 2;        // sum of three squares
  localparam int RW       = SUMW / 2;       // square root width and stage count
  localparam int QW       = NFB + 1;        // quotient width and divider stage count
  localparam int NW       = MW + NFB + 2;   // rounded dividend width
  localparam int DW       = RW + 1;         // doubled divisor width

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic               degen;
  } carry_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } sign_t;

endpackage

>>> rtl/tfn_in_if.sv
`timescale 1ns / 1ps
// Input channel of the face normal unit: one triangle per transfer.
// Depends on tfn_pkg for the coordinate width.
interface tfn_in_if;
  import tfn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] first_z;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;
  logic signed [CW-1:0] second_z;
  logic signed [CW-1:0] third_x;
  logic signed [CW-1:0] third_y;
  logic signed [CW-1:0] third_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                third_x, third_y, third_z, output ready);
endinterface

>>> rtl/tfn_out_if.sv
`timescale 1ns / 1ps
// Output channel of the face normal unit: one unit normal per transfer.
// Depends on tfn_pkg for the normal width.
interface tfn_out_if;
  import tfn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] normal_x;
  logic signed [OW-1:0] normal_y;
  logic signed [OW-1:0] normal_z;
  logic                 degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

>>> rtl/triangle_face_normal_unit.sv
`timescale 1ns / 1ps
// Triangle unit face normal: edges, cross product, normalize, square root, divide.
// One triangle per cycle is sustained while the output is not stalled.
// The length is taken by a 32-stage square root, one result bit per stage, and each
// component by a 15-stage restoring divider; all stages advance together and hold on a stall.
// Synchronous active-high reset clears every stage valid bit; payload is not reset.
// Depends on tfn_pkg, tfn_in_if and tfn_out_if.
module triangle_face_normal_unit
  import tfn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tfn_in_if.sink    tri_in,
  tfn_out_if.source nrm_out
);

  logic adv;

  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] p2 [3];
  logic signed [CW-1:0] p3 [3];

  logic                 s1_v;
  logic signed [EW-1:0] s1_a [3];
  logic signed [EW-1:0] s1_b [3];
  logic                 s2_v;
  logic signed [PW-1:0] s2_p [6];
  logic                 s3_v;
  logic [XW-1:0]        s3_mag [3];
  logic [2:0]           s3_neg;
  logic                 s4_v;
  logic [XW-1:0]        s4_mag [3];
  logic [2:0]           s4_neg;
  logic [TOPW-1:0]      s4_top;
  logic                 s4_deg;
  logic                 s5_v;
  carry_t               s5_c;
  logic                 s6_v;
  logic [SQW-1:0]       s6_sq [3];
  carry_t               s6_c;

  logic [SUMW-1:0] sq_n [RW+1];
  logic [SUMW-1:0] sq_r [RW+1];
  carry_t          sq_c [RW+1];
  logic            sq_v [RW+1];
  logic [SUMW-1:0] sq_n_next [RW+1];
  logic [SUMW-1:0] sq_r_next [RW+1];

  logic [NW-1:0]   dv_rem [QW+1][3];
  logic [QW-1:0]   dv_q   [QW+1][3];
  logic [DW-1:0]   dv_d   [QW+1];
  sign_t           dv_s   [QW+1];
  logic            dv_v   [QW+1];
  logic [NW-1:0]   dv_rem_next [QW+1][3];
  logic [QW-1:0]   dv_q_next   [QW+1][3];

  logic                 o_v;
  logic signed [OW-1:0] o_n [3];
  logic                 o_deg;

  logic [XW-1:0]   orv;
  logic [TOPW-1:0] top;
  logic [MW-1:0]   nmag [3];

  // The whole pipe moves when the output slot is empty or being drained.
  assign adv          = !o_v || nrm_out.ready;
  assign tri_in.ready = adv;

  assign p1[0] = tri_in.first_x;  assign p1[1] = tri_in.first_y;  assign p1[2] = tri_in.first_z;
  assign p2[0] = tri_in.second_x; assign p2[1] = tri_in.second_y; assign p2[2] = tri_in.second_z;
  assign p3[0] = tri_in.third_x;  assign p3[1] = tri_in.third_y;  assign p3[2] = tri_in.third_z;

  // The largest magnitude has the same leading bit as the OR of all three.
  always_comb begin
    orv = s3_mag[0] | s3_mag[1] | s3_mag[2];
    top = '0;
    for (int i = 0; i < XW; i++) begin
      if (orv[i]) top = TOPW'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s4_top >= TOPW'(NORM_TOP)) begin
        nmag[i] = MW'(s4_mag[i] >> (s4_top - TOPW'(NORM_TOP)));
      end else begin
        nmag[i] = MW'(s4_mag[i] << (TOPW'(NORM_TOP) - s4_top));
      end
    end
  end

  // Square root by digit recurrence, one result bit per stage.
  always_comb begin
    logic [SUMW-1:0] bitv;
    logic [SUMW-1:0] trial;
    sq_n_next[0] = '0;
    sq_r_next[0] = '0;
    for (int k = 0; k < RW; k++) begin
      bitv  = SUMW'(1) << (SUMW - 2 - 2 * k);
      trial = sq_r[k] + bitv;
      if (sq_n[k] >= trial) begin
        sq_n_next[k+1] = sq_n[k] - trial;
        sq_r_next[k+1] = (sq_r[k] >> 1) + bitv;
      end else begin
        sq_n_next[k+1] = sq_n[k];
        sq_r_next[k+1] = sq_r[k] >> 1;
      end
    end
  end

  // Restoring division, quotient bit QW-1-j resolved in stage j.
  always_comb begin
    logic [NW-1:0] dsh;
    for (int i = 0; i < 3; i++) begin
      dv_rem_next[0][i] = '0;
      dv_q_next[0][i]   = '0;
    end
    for (int j = 0; j < QW; j++) begin
      dsh = NW'(dv_d[j]) << (QW - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[j][i] >= dsh) begin
          dv_rem_next[j+1][i] = dv_rem[j][i] - dsh;
          dv_q_next[j+1][i]   = dv_q[j][i] | (QW'(1) << (QW - 1 - j));
        end else begin
          dv_rem_next[j+1][i] = dv_rem[j][i];
          dv_q_next[j+1][i]   = dv_q[j][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      for (int k = 0; k <= RW; k++) sq_v[k] <= 1'b0;
      for (int j = 0; j <= QW; j++) dv_v[j] <= 1'b0;
      o_v <= 1'b0;
    end else if (adv) begin
      s1_v    <= tri_in.valid;
      s2_v    <= s1_v;
      s3_v    <= s2_v;
      s4_v    <= s3_v;
      s5_v    <= s4_v;
      s6_v    <= s5_v;
      sq_v[0] <= s6_v;
      for (int k = 0; k < RW; k++) sq_v[k+1] <= sq_v[k];
      dv_v[0] <= sq_v[RW];
      for (int j = 0; j < QW; j++) dv_v[j+1] <= dv_v[j];
      o_v <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_a[i] <= EW'(p1[i]) - EW'(p2[i]);
        s1_b[i] <= EW'(p1[i]) - EW'(p3[i]);
      end

      s2_p[0] <= PW'(s1_a[1]) * PW'(s1_b[2]);
      s2_p[1] <= PW'(s1_b[1]) * PW'(s1_a[2]);
      s2_p[2] <= PW'(s1_b[0]) * PW'(s1_a[2]);
      s2_p[3] <= PW'(s1_a[0]) * PW'(s1_b[2]);
      s2_p[4] <= PW'(s1_a[0]) * PW'(s1_b[1]);
      s2_p[5] <= PW'(s1_b[0]) * PW'(s1_a[1]);

      for (int i = 0; i < 3; i++) begin
        logic signed [XW-1:0] c;
        c = XW'(s2_p[2*i]) - XW'(s2_p[2*i+1]);
        s3_neg[i] <= c[XW-1];
        s3_mag[i] <= c[XW-1] ? XW'(-c) : XW'(c);
      end

      s4_mag <= s3_mag;
      s4_neg <= s3_neg;
      s4_top <= top;
      s4_deg <= (orv == '0);

      for (int i = 0; i < 3; i++) s5_c.mag[i] <= nmag[i];
      s5_c.neg   <= s4_neg;
      s5_c.degen <= s4_deg;

      for (int i = 0; i < 3; i++) s6_sq[i] <= SQW'(s5_c.mag[i]) * SQW'(s5_c.mag[i]);
      s6_c <= s5_c;

      sq_n[0] <= SUMW'(s6_sq[0]) + SUMW'(s6_sq[1]) + SUMW'(s6_sq[2]);
      sq_r[0] <= '0;
      sq_c[0] <= s6_c;
      for (int k = 0; k < RW; k++) begin
        sq_n[k+1] <= sq_n_next[k+1];
        sq_r[k+1] <= sq_r_next[k+1];
        sq_c[k+1] <= sq_c[k];
      end

      // Rounded half up: (2*num + len) / (2*len).
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NW'(sq_c[RW].mag[i]) << (NFB + 1)) + NW'(sq_r[RW][RW-1:0]);
        dv_q[0][i]   <= '0;
      end
      dv_d[0]       <= {sq_r[RW][RW-1:0], 1'b0};
      dv_s[0].neg   <= sq_c[RW].neg;
      dv_s[0].degen <= sq_c[RW].degen;
      for (int j = 0; j < QW; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= dv_rem_next[j+1][i];
          dv_q[j+1][i]   <= dv_q_next[j+1][i];
        end
        dv_d[j+1] <= dv_d[j];
        dv_s[j+1] <= dv_s[j];
      end

      for (int i = 0; i < 3; i++) begin
        if (dv_s[QW].degen) begin
          o_n[i] <= '0;
        end else if (dv_s[QW].neg[i]) begin
          o_n[i] <= -OW'(dv_q[QW][i]);
        end else begin
          o_n[i] <= OW'(dv_q[QW][i]);
        end
      end
      o_deg <= dv_s[QW].degen;
    end
  end

  assign nrm_out.valid      = o_v;
  assign nrm_out.normal_x   = o_n[0];
  assign nrm_out.normal_y   = o_n[1];
  assign nrm_out.normal_z   = o_n[2];
  assign nrm_out.degenerate = o_deg;

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (o_v && o_deg) |-> (o_n[0] == '0 && o_n[1] == '0 && o_n[2] == '0))
    else $error("degenerate result with nonzero normal");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (dv_v[0] && !dv_s[0].degen) |-> (dv_d[0][DW-1:NORM_TOP+1] != '0))
    else $error("normalized length below range");

  a_quot_max: assert property (@(posedge clk) disable iff (rst)
    (dv_v[QW] && !dv_s[QW].degen) |->
      (dv_q[QW][0] <= QW'(1) << NFB && dv_q[QW][1] <= QW'(1) << NFB &&
       dv_q[QW][2] <= QW'(1) << NFB))
    else $error("normal component exceeds one");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s1_v) && $stable(sq_v[RW]) && $stable(dv_v[QW])))
    else $error("pipeline moved during a stall");

endmodule
